[sv/three_axis_pid_quad_mixer_core_assert.svh]
// Assertion macros shared by the PID quad mixer RTL.
// No dependencies; included by the lane and the top level.
`ifndef THREE_AXIS_PID_QUAD_MIXER_CORE_ASSERT_SVH
`define THREE_AXIS_PID_QUAD_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TAPQM_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tapqm assertion failed");

// Next-cycle implication, disabled while in reset.
`define TAPQM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tapqm assertion failed");

`endif

[sv/tapqm_pkg.sv]
// Shared types and constants for the three-axis PID quad mixer.
// No dependencies; used by every module of the block.
`default_nettype none

package tapqm_pkg;

  localparam int SAMPLE_WIDTH       = 16;
  localparam int SUM_WIDTH          = 32;
  localparam int MOTOR_WIDTH        = 12;
  localparam int GAIN_FRACTION_BITS = 8;
  localparam int GAIN_WIDTH         = 16;
  localparam int GAINS_WIDTH        = 3 * GAIN_WIDTH;
  localparam int LIMIT_WIDTH        = 15;
  localparam int CFG_DATA_WIDTH     = GAINS_WIDTH;
  localparam int CFG_INDEX_WIDTH    = 3;
  localparam int AXIS_WIDTH         = SAMPLE_WIDTH + GAIN_WIDTH + 4;
  localparam int MIX_WIDTH          = AXIS_WIDTH + 2;

  localparam logic [MOTOR_WIDTH-1:0] LOW_THROTTLE = MOTOR_WIDTH'(10);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROLL_GAINS     = 3'd0,
    CFG_PITCH_GAINS    = 3'd1,
    CFG_YAW_GAINS      = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_MOTOR_MIN      = 3'd4,
    CFG_MOTOR_MAX      = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] roll_setpoint;
    logic signed [SAMPLE_WIDTH-1:0] pitch_setpoint;
    logic signed [SAMPLE_WIDTH-1:0] yaw_setpoint;
    logic        [MOTOR_WIDTH-1:0]  throttle;
    logic signed [SAMPLE_WIDTH-1:0] roll_measured;
    logic signed [SAMPLE_WIDTH-1:0] pitch_measured;
    logic signed [SAMPLE_WIDTH-1:0] yaw_measured;
    logic                           armed;
  } in_data_t;

  typedef struct packed {
    logic [MOTOR_WIDTH-1:0] motor_one;
    logic [MOTOR_WIDTH-1:0] motor_two;
    logic [MOTOR_WIDTH-1:0] motor_three;
    logic [MOTOR_WIDTH-1:0] motor_four;
  } out_data_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic out;
  } stage_en_t;

  typedef struct packed {
    logic first;
    logic clear;
  } axis_ctl_t;

endpackage

`default_nettype wire

[sv/tapqm_pid_lane.sv]
// One PID axis lane: error, saturating sum, derivative on measurement,
// gain products and axis output. Depends on tapqm_pkg and the assert header.
`default_nettype none

`include "three_axis_pid_quad_mixer_core_assert.svh"

module tapqm_pid_lane #(
  parameter int   SUM_WIDTH          = tapqm_pkg::SUM_WIDTH,
  parameter int   GAIN_FRACTION_BITS = tapqm_pkg::GAIN_FRACTION_BITS,
  parameter logic NEGATE_SP          = 1'b0
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire tapqm_pkg::stage_en_t                         en,
  input  wire tapqm_pkg::axis_ctl_t                         ctl,
  input  wire logic signed [tapqm_pkg::SAMPLE_WIDTH-1:0]    setpoint,
  input  wire logic signed [tapqm_pkg::SAMPLE_WIDTH-1:0]    measured,
  input  wire logic        [tapqm_pkg::GAINS_WIDTH-1:0]     gains,
  input  wire logic        [tapqm_pkg::LIMIT_WIDTH-1:0]     integral_limit,
  output logic signed      [tapqm_pkg::AXIS_WIDTH-1:0]      axis_out
);

  localparam int SW  = tapqm_pkg::SAMPLE_WIDTH;
  localparam int GW  = tapqm_pkg::GAIN_WIDTH;
  localparam int AW  = tapqm_pkg::AXIS_WIDTH;
  localparam int EW  = SW + 2;
  localparam int DW  = SW + 1;
  localparam int XW  = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam int PW  = EW + GW + 1;
  localparam int IW  = SUM_WIDTH + GW + 1;
  localparam int DPW = DW + GW + 1;
  localparam logic signed [XW-1:0] SMAX = $signed(XW'({1'b0, {(SUM_WIDTH-1){1'b1}}}));
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [SW-1:0]        prev_r;
  logic signed [EW-1:0]        err_r;
  logic signed [SUM_WIDTH-1:0] isum_r;
  logic signed [DW-1:0]        delta_r;
  logic signed [PW-1:0]        prod_p_r;
  logic signed [IW-1:0]        prod_i_r;
  logic signed [DPW-1:0]       prod_d_r;
  logic signed [AW-1:0]        axis_r;

  logic signed [EW-1:0]        sp_x;
  logic signed [EW-1:0]        err;
  logic signed [XW-1:0]        sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [DW-1:0]        delta;
  logic signed [PW-1:0]        prod_p;
  logic signed [IW-1:0]        prod_i;
  logic signed [DPW-1:0]       prod_d;
  logic signed [PW-1:0]        p_sh;
  logic signed [IW-1:0]        i_sh;
  logic signed [IW-1:0]        lim;
  logic signed [IW-1:0]        i_clamp;
  logic signed [DPW-1:0]       d_sh;

  // stage 1: error, saturating sum, measurement delta
  always_comb begin
    sp_x     = NEGATE_SP ? -EW'(setpoint) : EW'(setpoint);
    err      = sp_x - EW'(measured);
    sum_wide = XW'(sum_r) + XW'(err);
    if (sum_wide > SMAX) begin
      sum_sat = SMAX[SUM_WIDTH-1:0];
    end else if (sum_wide < SMIN) begin
      sum_sat = SMIN[SUM_WIDTH-1:0];
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
    delta = DW'(measured) - DW'(prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (en.s1) begin
      sum_r  <= ctl.clear ? '0 : sum_sat;
      prev_r <= measured;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      err_r   <= err;
      isum_r  <= sum_sat;
      delta_r <= ctl.first ? '0 : delta;
    end
  end

  // stage 2: gain products
  assign prod_p = PW'($signed({1'b0, gains[GW-1:0]})) * PW'(err_r);
  assign prod_i = IW'($signed({1'b0, gains[2*GW-1:GW]})) * IW'(isum_r);
  assign prod_d = DPW'($signed({1'b0, gains[3*GW-1:2*GW]})) * DPW'(delta_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_p_r <= prod_p;
      prod_i_r <= prod_i;
      prod_d_r <= prod_d;
    end
  end

  // stage 3: floor shift, integral clamp, axis output
  always_comb begin
    p_sh = prod_p_r >>> GAIN_FRACTION_BITS;
    i_sh = prod_i_r >>> GAIN_FRACTION_BITS;
    d_sh = prod_d_r >>> GAIN_FRACTION_BITS;
    lim  = $signed(IW'({1'b0, integral_limit}));
    if (i_sh > lim) begin
      i_clamp = lim;
    end else if (i_sh < -lim) begin
      i_clamp = -lim;
    end else begin
      i_clamp = i_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      axis_r <= AW'(p_sh) + AW'(i_clamp) - AW'(d_sh);
    end
  end

  assign axis_out = axis_r;

  `TAPQM_ASSERT_NEXT(a_sum_cleared, clk, rst_n, en.s1 && ctl.clear, sum_r == '0)
  `TAPQM_ASSERT_NEXT(a_first_delta_zero, clk, rst_n, en.s1 && ctl.first, delta_r == '0)

endmodule

`default_nettype wire

[sv/tapqm_mixer.sv]
// X-frame motor mixer: four motor sums, absolute value and range clamp
// into the output register. Depends on tapqm_pkg.
`default_nettype none

module tapqm_mixer (
  input  wire logic                                     clk,
  input  wire tapqm_pkg::stage_en_t                     en,
  input  wire logic signed [tapqm_pkg::AXIS_WIDTH-1:0]  roll_axis,
  input  wire logic signed [tapqm_pkg::AXIS_WIDTH-1:0]  pitch_axis,
  input  wire logic signed [tapqm_pkg::AXIS_WIDTH-1:0]  yaw_axis,
  input  wire logic        [tapqm_pkg::MOTOR_WIDTH-1:0] throttle,
  input  wire logic        [tapqm_pkg::MOTOR_WIDTH-1:0] motor_min,
  input  wire logic        [tapqm_pkg::MOTOR_WIDTH-1:0] motor_max,
  output tapqm_pkg::out_data_t                          out_data
);

  localparam int MW = tapqm_pkg::MIX_WIDTH;
  localparam int OW = tapqm_pkg::MOTOR_WIDTH;

  logic signed [MW-1:0] sum_r [4];
  tapqm_pkg::out_data_t out_r;

  logic signed [MW-1:0] t_x;
  logic signed [MW-1:0] r_x;
  logic signed [MW-1:0] p_x;
  logic signed [MW-1:0] y_x;
  logic        [OW-1:0] motor [4];

  function automatic logic [OW-1:0] clamp_motor(input logic signed [MW-1:0] v,
                                                input logic [OW-1:0] lo,
                                                input logic [OW-1:0] hi);
    logic [MW-1:0] mag;
    mag = v[MW-1] ? MW'(-v) : MW'(v);
    if (mag > MW'(hi)) begin
      clamp_motor = hi;
    end else if (mag < MW'(lo)) begin
      clamp_motor = lo;
    end else begin
      clamp_motor = mag[OW-1:0];
    end
  endfunction

  always_comb begin
    t_x = $signed(MW'({1'b0, throttle}));
    r_x = MW'(roll_axis);
    p_x = MW'(pitch_axis);
    y_x = MW'(yaw_axis);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sum_r[0] <= t_x + r_x - p_x - y_x;
      sum_r[1] <= t_x - r_x - p_x + y_x;
      sum_r[2] <= t_x - r_x + p_x - y_x;
      sum_r[3] <= t_x + r_x + p_x + y_x;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      motor[i] = clamp_motor(sum_r[i], motor_min, motor_max);
    end
  end

  always_ff @(posedge clk) begin
    if (en.out) begin
      out_r.motor_one   <= motor[0];
      out_r.motor_two   <= motor[1];
      out_r.motor_three <= motor[2];
      out_r.motor_four  <= motor[3];
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[sv/three_axis_pid_quad_mixer_core.sv]
// Three-axis PID controller with X-frame quad motor mixing.
// Depends on tapqm_pkg, tapqm_pid_lane, tapqm_mixer and the assert header.
//
// Usage:
//   Each transfer on the in_ channel is one control tick: setpoints,
//   throttle, measured roll/pitch/yaw and the armed flag. Each tick yields
//   exactly one transfer on the out_ channel with the four motor values.
//   Gains, integral limit and motor range are written through cfg_wr_en,
//   cfg_index and cfg_wdata while no tick is in flight.
// Throughput and stages:
//   One tick per cycle sustained while out_ready stays high. Stages:
//   error and sums, gain multipliers, axis outputs, motor sums, clamp
//   and output register. Three axis lanes run in parallel and feed the
//   mixer.
// Reset:
//   Error sums and last measurements clear, the first tick after reset
//   takes a zero derivative, registers return to their defaults.
// Back-pressure:
//   When out_ready is low the result holds; earlier stages keep filling
//   until the pipeline is full, then in_ready drops.
`default_nettype none

`include "three_axis_pid_quad_mixer_core_assert.svh"

module three_axis_pid_quad_mixer_core #(
  parameter int SUM_WIDTH          = tapqm_pkg::SUM_WIDTH,
  parameter int GAIN_FRACTION_BITS = tapqm_pkg::GAIN_FRACTION_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire tapqm_pkg::in_data_t                      in_data,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output tapqm_pkg::out_data_t                          out_data,
  input  wire logic                                     cfg_wr_en,
  input  wire logic [tapqm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [tapqm_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);

  localparam int GSW = tapqm_pkg::GAINS_WIDTH;
  localparam int LW  = tapqm_pkg::LIMIT_WIDTH;
  localparam int OW  = tapqm_pkg::MOTOR_WIDTH;
  localparam int AW  = tapqm_pkg::AXIS_WIDTH;

  logic [GSW-1:0] roll_gains_r;
  logic [GSW-1:0] pitch_gains_r;
  logic [GSW-1:0] yaw_gains_r;
  logic [LW-1:0]  integral_limit_r;
  logic [OW-1:0]  motor_min_r;
  logic [OW-1:0]  motor_max_r;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy2, rdy3, rdy4, rdy_o;
  logic prev_armed_r;
  logic first_tick_r;
  logic [OW-1:0] thr1_r, thr2_r, thr3_r;

  tapqm_pkg::stage_en_t en;
  tapqm_pkg::axis_ctl_t ctl;

  logic signed [AW-1:0] roll_axis;
  logic signed [AW-1:0] pitch_axis;
  logic signed [AW-1:0] yaw_axis;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_gains_r     <= '0;
      pitch_gains_r    <= '0;
      yaw_gains_r      <= '0;
      integral_limit_r <= '1;
      motor_min_r      <= '0;
      motor_max_r      <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tapqm_pkg::CFG_ROLL_GAINS:     roll_gains_r     <= cfg_wdata[GSW-1:0];
        tapqm_pkg::CFG_PITCH_GAINS:    pitch_gains_r    <= cfg_wdata[GSW-1:0];
        tapqm_pkg::CFG_YAW_GAINS:      yaw_gains_r      <= cfg_wdata[GSW-1:0];
        tapqm_pkg::CFG_INTEGRAL_LIMIT: integral_limit_r <= cfg_wdata[LW-1:0];
        tapqm_pkg::CFG_MOTOR_MIN:      motor_min_r      <= cfg_wdata[OW-1:0];
        tapqm_pkg::CFG_MOTOR_MAX:      motor_max_r      <= cfg_wdata[OW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy_o    = !vo_r || out_ready;
    rdy4     = !v4_r || rdy_o;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    in_ready = !v1_r || rdy2;
    en.s1    = in_valid && in_ready;
    en.s2    = v1_r && rdy2;
    en.s3    = v2_r && rdy3;
    en.s4    = v3_r && rdy4;
    en.out   = v4_r && rdy_o;
    ctl.first = first_tick_r;
    ctl.clear = (in_data.throttle < tapqm_pkg::LOW_THROTTLE) ||
                (in_data.armed != prev_armed_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      vo_r         <= 1'b0;
      prev_armed_r <= 1'b0;
      first_tick_r <= 1'b1;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     v4_r <= v3_r;
      if (rdy_o)    vo_r <= v4_r;
      if (en.s1) begin
        prev_armed_r <= in_data.armed;
        first_tick_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) thr1_r <= in_data.throttle;
    if (en.s2) thr2_r <= thr1_r;
    if (en.s3) thr3_r <= thr2_r;
  end

  tapqm_pid_lane #(
    .SUM_WIDTH          (SUM_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .NEGATE_SP          (1'b1)
  ) u_roll (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .ctl            (ctl),
    .setpoint       (in_data.roll_setpoint),
    .measured       (in_data.roll_measured),
    .gains          (roll_gains_r),
    .integral_limit (integral_limit_r),
    .axis_out       (roll_axis)
  );

  tapqm_pid_lane #(
    .SUM_WIDTH          (SUM_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .NEGATE_SP          (1'b1)
  ) u_pitch (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .ctl            (ctl),
    .setpoint       (in_data.pitch_setpoint),
    .measured       (in_data.pitch_measured),
    .gains          (pitch_gains_r),
    .integral_limit (integral_limit_r),
    .axis_out       (pitch_axis)
  );

  tapqm_pid_lane #(
    .SUM_WIDTH          (SUM_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .NEGATE_SP          (1'b0)
  ) u_yaw (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .ctl            (ctl),
    .setpoint       (in_data.yaw_setpoint),
    .measured       (in_data.yaw_measured),
    .gains          (yaw_gains_r),
    .integral_limit (integral_limit_r),
    .axis_out       (yaw_axis)
  );

  tapqm_mixer u_mixer (
    .clk        (clk),
    .en         (en),
    .roll_axis  (roll_axis),
    .pitch_axis (pitch_axis),
    .yaw_axis   (yaw_axis),
    .throttle   (thr3_r),
    .motor_min  (motor_min_r),
    .motor_max  (motor_max_r),
    .out_data   (out_data)
  );

  assign out_valid = vo_r;

  `TAPQM_ASSERT_IMPLIES(a_first_falls_on_transfer, clk, rst_n, $fell(first_tick_r), $past(en.s1))
  `TAPQM_ASSERT_IMPLIES(a_full_pipe_stalls_input, clk, rst_n, vo_r && !out_ready && v4_r && v3_r && v2_r && v1_r, !in_ready)

endmodule

`default_nettype wire
